// ===== design/spm_pkg.sv =====
// Package: shared request/result types and opcode codes for the substring matcher.
`timescale 1ns / 1ps
package spm_pkg;

  typedef enum logic {
    OP_TEXT = 1'b0,
    OP_WORD = 1'b1
  } op_t;

  typedef struct packed {
    op_t        opcode;
    logic [7:0] ch;
    logic       last;
  } in_t;

  typedef struct packed {
    logic found;
    logic overflow;
  } out_t;

endpackage

// ===== design/spm_text.sv =====
// Text store: holds the stored text and compares every position with the request character.
`timescale 1ns / 1ps
module spm_text #(
  parameter int MAX_LEN = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_vld,
  input  spm_pkg::in_t       req,
  output logic [MAX_LEN-1:0] match_vec,
  output logic               text_ovf
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [7:0]       store_r [MAX_LEN];
  logic [LEN_W-1:0] len_r, len_nxt, base_len;
  logic             done_r, done_nxt;
  logic             ovf_r, ovf_nxt;
  logic             wr_en;
  logic             is_text;

  assign is_text  = req_vld && (req.opcode == spm_pkg::OP_TEXT);
  assign base_len = done_r ? '0 : len_r;
  assign wr_en    = is_text && (base_len < LEN_W'(MAX_LEN));

  always_comb begin
    len_nxt  = len_r;
    ovf_nxt  = ovf_r;
    done_nxt = done_r;
    if (is_text) begin
      done_nxt = req.last;
      if (wr_en) begin
        len_nxt = base_len + LEN_W'(1);
        ovf_nxt = done_r ? 1'b0 : ovf_r;
      end else begin
        len_nxt = base_len;
        ovf_nxt = 1'b1;
      end
    end else if (req_vld) begin
      // a candidate character closes any open text
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      done_r <= 1'b1;
      ovf_r  <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      done_r <= done_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_LEN; i++) begin
      if (wr_en && (base_len[IDX_W-1:0] == IDX_W'(i))) begin
        store_r[i] <= req.ch;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_LEN; i++) begin
      match_vec[i] = (LEN_W'(i) < len_r) && (store_r[i] == req.ch);
    end
  end

  assign text_ovf = ovf_r;

endmodule

// ===== design/spm_match.sv =====
// Matcher: alive bit per start offset, candidate position and result decision.
`timescale 1ns / 1ps
module spm_match #(
  parameter int MAX_LEN = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_vld,
  input  spm_pkg::in_t       req,
  input  logic [MAX_LEN-1:0] match_vec,
  input  logic               text_ovf,
  output logic               res_vld,
  output spm_pkg::out_t      res
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);

  logic [LEN_W-1:0]   pos_r, pos_nxt;
  logic [MAX_LEN-1:0] alive_r, alive_nxt, alive_upd;
  logic               povf_r, povf_nxt, povf_upd;
  logic               is_word;
  logic               in_range;

  assign is_word  = req_vld && (req.opcode == spm_pkg::OP_WORD);
  assign in_range = pos_r < LEN_W'(MAX_LEN);

  // offset o survives if text[o + pos] matches; shift fills past the text end with zeros
  assign alive_upd = in_range ? (alive_r & (match_vec >> pos_r)) : alive_r;
  assign povf_upd  = povf_r || !in_range;

  always_comb begin
    pos_nxt   = pos_r;
    alive_nxt = alive_r;
    povf_nxt  = povf_r;
    res_vld   = 1'b0;
    res       = '0;
    if (req_vld) begin
      if (!is_word || req.last) begin
        pos_nxt   = '0;
        alive_nxt = '1;
        povf_nxt  = 1'b0;
      end else begin
        pos_nxt   = in_range ? pos_r + LEN_W'(1) : pos_r;
        alive_nxt = alive_upd;
        povf_nxt  = povf_upd;
      end
      if (is_word && req.last) begin
        res_vld      = 1'b1;
        res.overflow = text_ovf || povf_upd;
        res.found    = (|alive_upd) && !(text_ovf || povf_upd);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      alive_r <= '1;
      povf_r  <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      alive_r <= alive_nxt;
      povf_r  <= povf_nxt;
    end
  end

endmodule

// ===== design/substring_presence_matcher_core.sv =====
// Top level: substring presence matcher with registered result stage.
//
//   channel | ports                          | moves
//   --------+--------------------------------+------------------------------
//   input   | in_valid, in_ready, in_payload | text or candidate characters
//   result  | out_valid, out_ready, out_payload | found / overflow per candidate
//
// One request per cycle while in_ready is high; all offsets are compared in parallel.
// A result appears in the output register in the cycle after the last candidate
// character is accepted. in_ready drops only while a result waits unread.
// Synchronous active-low reset clears text length and result valid and sets all alive bits.
`timescale 1ns / 1ps
module substring_presence_matcher_core #(
  parameter int MAX_LEN = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  spm_pkg::in_t  in_payload,
  output logic          out_valid,
  input  logic          out_ready,
  output spm_pkg::out_t out_payload
);

  logic               acc;
  logic [MAX_LEN-1:0] match_vec;
  logic               text_ovf;
  logic               res_vld;
  spm_pkg::out_t      res;
  logic               out_valid_r, out_valid_nxt;
  spm_pkg::out_t      out_payload_r;

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;

  spm_text #(.MAX_LEN(MAX_LEN)) u_text (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_vld   (acc),
    .req       (in_payload),
    .match_vec (match_vec),
    .text_ovf  (text_ovf)
  );

  spm_match #(.MAX_LEN(MAX_LEN)) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_vld   (acc),
    .req       (in_payload),
    .match_vec (match_vec),
    .text_ovf  (text_ovf),
    .res_vld   (res_vld),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc && res_vld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && res_vld) begin
      out_payload_r <= res;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

  a_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_payload_r.found && out_payload_r.overflow))
    else $error("found raised together with overflow");

  a_word_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_payload.opcode == spm_pkg::OP_WORD && in_payload.last) |=> out_valid_r)
    else $error("candidate end gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !(in_payload.opcode == spm_pkg::OP_WORD && in_payload.last) && out_ready)
      |=> !out_valid_r)
    else $error("result without candidate end");

endmodule

// ===== dv/tb_substring_presence_matcher_core.sv =====
// Testbench for substring_presence_matcher_core: directed and random text/candidate traffic.
`timescale 1ns / 1ps
module tb_substring_presence_matcher_core;

  localparam int MAX_LEN    = 32;
  localparam int IDLE_LIMIT = 2000;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  spm_pkg::in_t  in_payload;
  logic          out_valid;
  logic          out_ready;
  spm_pkg::out_t out_payload;

  substring_presence_matcher_core #(.MAX_LEN(MAX_LEN)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_payload(out_payload)
  );

  // predictor state
  logic [7:0]         txt_mem [MAX_LEN];
  int                 txt_len;
  bit                 txt_done;
  bit                 txt_ovf;
  int                 word_pos;
  logic [MAX_LEN-1:0] alive;
  bit                 word_ovf;

  spm_pkg::out_t verdicts [$];
  int            errors;
  int            items_sent;
  bit            tx_no_idle;
  bit            rx_no_idle;
  int            rx_hold_req;
  logic [7:0]    cur_text [$];
  logic [7:0]    word_buf [$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic spm_pkg::in_t mk_req(spm_pkg::op_t op, logic [7:0] c, logic lst);
    spm_pkg::in_t r;
    r.opcode = op;
    r.ch     = c;
    r.last   = lst;
    return r;
  endfunction

  function automatic void clear_word();
    word_pos = 0;
    alive    = '1;
    word_ovf = 1'b0;
  endfunction

  function automatic void predict_verdict(spm_pkg::in_t r);
    logic [MAX_LEN-1:0] keep;
    spm_pkg::out_t      v;
    if (r.opcode == spm_pkg::OP_TEXT) begin
      clear_word();
      if (txt_done) begin
        txt_len  = 0;
        txt_ovf  = 1'b0;
        txt_done = 1'b0;
      end
      if (txt_len < MAX_LEN) begin
        txt_mem[txt_len] = r.ch;
        txt_len++;
      end else begin
        txt_ovf = 1'b1;
      end
      if (r.last) txt_done = 1'b1;
    end else begin
      txt_done = 1'b1;
      if (word_pos < MAX_LEN) begin
        keep = '0;
        for (int o = 0; o < MAX_LEN; o++)
          if (o + word_pos < txt_len && txt_mem[o + word_pos] == r.ch) keep[o] = 1'b1;
        alive &= keep;
        word_pos++;
      end else begin
        word_ovf = 1'b1;
      end
      if (r.last) begin
        v.overflow = txt_ovf || word_ovf;
        v.found    = (|alive) && !v.overflow;
        verdicts.push_back(v);
        clear_word();
      end
    end
  endfunction

  task automatic send_req(spm_pkg::in_t r);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_payload <= r;
    do @(posedge clk); while (!in_ready);
    predict_verdict(r);
    items_sent++;
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_ch();
    if ($urandom_range(0, 3) != 0) return 8'h61 + 8'($urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_text(bit fresh, bit close);
    if (fresh) cur_text.delete();
    foreach (word_buf[i]) begin
      cur_text.push_back(word_buf[i]);
      send_req(mk_req(spm_pkg::OP_TEXT, word_buf[i], close && i == word_buf.size() - 1));
    end
  endtask

  task automatic send_word(bit close);
    foreach (word_buf[i])
      send_req(mk_req(spm_pkg::OP_WORD, word_buf[i], close && i == word_buf.size() - 1));
  endtask

  // result checker and receiver stalls
  initial begin
    spm_pkg::out_t got;
    spm_pkg::out_t want;
    int            stall_left;
    int            hold_left;
    out_ready <= 1'b0;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got = out_payload;
        if (verdicts.size() == 0) begin
          $error("result with no request pending: found %0b overflow %0b",
                 got.found, got.overflow);
          errors++;
        end else begin
          want = verdicts.pop_front();
          if (got.found !== want.found) begin
            $error("found mismatch: expected %0b, got %0b", want.found, got.found);
            errors++;
          end
          if (got.overflow !== want.overflow) begin
            $error("overflow mismatch: expected %0b, got %0b", want.overflow, got.overflow);
            errors++;
          end
        end
        stall_left = rx_no_idle ? 0 : $urandom_range(0, 13);
      end
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on accepted requests and results
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic test_empty_text();
    send_req(mk_req(spm_pkg::OP_WORD, 8'h61, 1'b1));
    send_req(mk_req(spm_pkg::OP_WORD, 8'h00, 1'b1));
  endtask

  task automatic test_basic_match();
    word_buf = {8'h61, 8'h62, 8'hFF, 8'h01};
    send_text(1'b1, 1'b1);
    word_buf = {8'h62, 8'hFF};
    send_word(1'b1);
    word_buf = {8'h01};
    send_word(1'b1);
    word_buf = {8'h01, 8'h61};
    send_word(1'b1);
    word_buf = {8'h61, 8'h62, 8'hFF, 8'h01};
    send_word(1'b1);
    word_buf = {8'h00};
    send_word(1'b1);
  endtask

  task automatic test_interruptions();
    send_req(mk_req(spm_pkg::OP_WORD, 8'h61, 1'b0));
    word_buf = {8'h78, 8'h79};
    send_text(1'b1, 1'b1);
    word_buf = {8'h79};
    send_word(1'b1);
    word_buf = {8'h70, 8'h71};
    send_text(1'b1, 1'b0);
    word_buf = {8'h71};
    send_word(1'b1);
    word_buf = {8'h70, 8'h71};
    send_word(1'b1);
  endtask

  task automatic test_length_limits();
    word_buf.delete();
    for (int i = 0; i < MAX_LEN + 2; i++) word_buf.push_back(8'h61);
    send_text(1'b1, 1'b1);
    word_buf = {8'h61};
    send_word(1'b1);
    word_buf.delete();
    for (int i = 0; i < MAX_LEN; i++) word_buf.push_back(8'h80 + 8'(i));
    send_text(1'b1, 1'b1);
    send_word(1'b1);
    word_buf.push_back(8'h80);
    send_word(1'b1);
  endtask

  task automatic test_result_backpressure();
    wait_all_results();
    word_buf = {8'h61, 8'h62, 8'h63, 8'h61, 8'h62};
    send_text(1'b1, 1'b1);
    wait_all_results();
    tx_no_idle  = 1'b1;
    rx_hold_req = 150;
    for (int i = 0; i < 8; i++) begin
      word_buf = {rand_ch(), rand_ch()};
      send_word(1'b1);
    end
    tx_no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    int start;
    int next_mode;
    int kind;
    int n;
    int off;
    start     = items_sent;
    next_mode = items_sent;
    while (items_sent - start < 220) begin
      if (items_sent >= next_mode) begin
        tx_no_idle = ($urandom_range(0, 3) == 0);
        rx_no_idle = ($urandom_range(0, 3) == 0);
        next_mode  = items_sent + 60;
      end
      kind = $urandom_range(0, 9);
      if (kind <= 7) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_LEN + 1, MAX_LEN + 4)
                                        : $urandom_range(1, 12);
        word_buf.delete();
        repeat (n) word_buf.push_back(rand_ch());
        // kind 7: candidate closes a text that never saw its last character
        send_text(1'b1, kind != 7);
        repeat ($urandom_range(1, 4)) begin
          word_buf.delete();
          if ($urandom_range(0, 9) < 6 && cur_text.size() != 0) begin
            off = $urandom_range(0, cur_text.size() - 1);
            n   = $urandom_range(1, cur_text.size() - off);
            for (int i = 0; i < n; i++) word_buf.push_back(cur_text[off + i]);
            if ($urandom_range(0, 3) == 0)
              word_buf[$urandom_range(0, n - 1)] = rand_ch();
          end else begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MAX_LEN + 4)
                                            : $urandom_range(1, 6);
            repeat (n) word_buf.push_back(rand_ch());
          end
          send_word(1'b1);
        end
      end else if (kind == 8) begin
        // partial candidate left open for whatever request comes next
        word_buf.delete();
        repeat ($urandom_range(1, 4)) word_buf.push_back(rand_ch());
        send_word(1'b0);
      end else begin
        repeat ($urandom_range(1, 6))
          send_req(mk_req(spm_pkg::op_t'($urandom_range(0, 1)), rand_ch(),
                          1'($urandom_range(0, 1))));
      end
    end
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  initial begin
    errors      = 0;
    items_sent  = 0;
    tx_no_idle  = 1'b0;
    rx_no_idle  = 1'b0;
    rx_hold_req = 0;
    foreach (txt_mem[i]) txt_mem[i] = 8'h00;
    txt_len  = 0;
    txt_done = 1'b1;
    txt_ovf  = 1'b0;
    clear_word();
    in_valid   <= 1'b0;
    in_payload <= mk_req(spm_pkg::OP_TEXT, 8'h00, 1'b0);
    rst_n      <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_text();
    test_basic_match();
    test_interruptions();
    wait_all_results();
    test_length_limits();
    wait_all_results();
    test_result_backpressure();
    wait_all_results();
    test_random_traffic();
    wait_all_results();
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
